>>> rtl/core/multiplexed_segment_display_scanner_unit_macros.svh
// Assertion macros shared by the display scanner RTL.
`ifndef MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_UNIT_MACROS_SVH
`define MULTIPLEXED_SEGMENT_DISPLAY_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/msds_pkg.sv
// Package: word types, command codes, fonts and select table of the display scanner.
`default_nettype none
package msds_pkg;

  localparam int DEF_UPPER_DIGITS  = 6;
  localparam int DEF_LOWER_DIGITS  = 5;
  localparam int DEF_TURRET_DIGITS = 4;
  localparam int DEF_LED_COUNT     = 16;
  localparam int STORE_DEPTH       = 16;
  localparam int SELECT_ENTRIES    = 12;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_RAW   = 3'd2;
  localparam logic [2:0] OP_LED   = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [1:0] GRP_UPPER  = 2'd0;
  localparam logic [1:0] GRP_LOWER  = 2'd1;
  localparam logic [1:0] GRP_TURRET = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  group;
    logic [3:0]  position;
    logic [7:0]  character;
    logic [15:0] raw_data;
    logic        enable;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        is_turret;
    logic [15:0] segment_data;
    logic [3:0]  select_code;
  } res_word_t;

  // sixteen-segment bits
  localparam logic [15:0] WA1 = 16'h0001;
  localparam logic [15:0] WA2 = 16'h0002;
  localparam logic [15:0] WB  = 16'h0004;
  localparam logic [15:0] WC  = 16'h0008;
  localparam logic [15:0] WD1 = 16'h0010;
  localparam logic [15:0] WD2 = 16'h0020;
  localparam logic [15:0] WE  = 16'h0040;
  localparam logic [15:0] WF  = 16'h0080;
  localparam logic [15:0] WG1 = 16'h0100;
  localparam logic [15:0] WG2 = 16'h0200;
  localparam logic [15:0] WH  = 16'h0400;
  localparam logic [15:0] WI  = 16'h0800;
  localparam logic [15:0] WJ  = 16'h1000;
  localparam logic [15:0] WK  = 16'h2000;
  localparam logic [15:0] WL  = 16'h4000;
  localparam logic [15:0] WM  = 16'h8000;

  // seven-segment bits
  localparam logic [7:0] NA = 8'h01;
  localparam logic [7:0] NB = 8'h02;
  localparam logic [7:0] NC = 8'h04;
  localparam logic [7:0] ND = 8'h08;
  localparam logic [7:0] NE = 8'h10;
  localparam logic [7:0] NF = 8'h20;
  localparam logic [7:0] NG = 8'h40;

  localparam logic [15:0] WIDE_DIGITS [10] = '{
    WA1|WA2|WB|WC|WD1|WD2|WE|WF,
    WB|WC,
    WA1|WA2|WB|WG1|WG2|WE|WD1|WD2,
    WA1|WA2|WB|WC|WD1|WD2|WG1|WG2,
    WB|WC|WG1|WG2|WF,
    WA1|WA2|WC|WD1|WD2|WF|WG1|WG2,
    WA1|WA2|WC|WD1|WD2|WE|WF|WG1|WG2,
    WA1|WA2|WB|WC,
    WA1|WA2|WB|WC|WD1|WD2|WE|WF|WG1|WG2,
    WA1|WA2|WB|WC|WD1|WD2|WF|WG1|WG2
  };

  localparam logic [15:0] WIDE_LETTERS [26] = '{
    WA1|WA2|WB|WC|WE|WF|WG1|WG2,
    WA1|WA2|WB|WC|WD1|WD2|WG2|WI|WL,
    WA1|WA2|WD1|WD2|WE|WF,
    WA1|WA2|WB|WC|WD1|WD2|WI|WL,
    WA1|WA2|WD1|WD2|WE|WF|WG1|WG2,
    WA1|WA2|WE|WF|WG1,
    WA1|WA2|WC|WD1|WD2|WE|WF|WG2,
    WB|WC|WE|WF|WG1|WG2,
    WA1|WA2|WI|WL|WD1|WD2,
    WB|WC|WD1|WD2|WE,
    WE|WF|WG1|WJ|WK,
    WD1|WD2|WE|WF,
    WB|WC|WE|WF|WH|WJ,
    WB|WC|WE|WF|WH|WK,
    WA1|WA2|WB|WC|WD1|WD2|WE|WF,
    WA1|WA2|WB|WE|WF|WG1|WG2,
    WA1|WA2|WB|WC|WD1|WD2|WE|WF|WK,
    WA1|WA2|WB|WE|WF|WG1|WG2|WK,
    WA1|WA2|WC|WD1|WD2|WF|WG1|WG2,
    WA1|WA2|WI|WL,
    WB|WC|WD1|WD2|WE|WF,
    WE|WF|WJ|WM,
    WB|WC|WE|WF|WK|WM,
    WH|WJ|WK|WM,
    WH|WJ|WL,
    WA1|WA2|WD1|WD2|WJ|WM
  };

  localparam logic [7:0] NARROW_DIGITS [10] = '{
    NA|NB|NC|ND|NE|NF, NB|NC, NA|NB|ND|NE|NG, NA|NB|NC|ND|NG, NB|NC|NF|NG,
    NA|NC|ND|NF|NG, NA|NC|ND|NE|NF|NG, NA|NB|NC, NA|NB|NC|ND|NE|NF|NG,
    NA|NB|NC|ND|NF|NG
  };

  localparam logic [7:0] NARROW_LETTERS [26] = '{
    NA|NB|NC|NE|NF|NG, NC|ND|NE|NF|NG, NA|ND|NE|NF, NB|NC|ND|NE|NG,
    NA|ND|NE|NF|NG, NA|NE|NF|NG, NA|NC|ND|NE|NF, NB|NC|NE|NF|NG,
    NB|NC, NB|NC|ND|NE, NB|NE|NF|NG, ND|NE|NF,
    NA|NC|NE|NG, NC|NE|NG, NA|NB|NC|ND|NE|NF, NA|NB|NE|NF|NG,
    NA|NB|NC|NF|NG, NE|NG, NA|NC|ND|NF|NG, ND|NE|NF|NG,
    NB|NC|ND|NE|NF, NC|ND|NE, NA|ND|NG, NA|ND|NG,
    NB|NC|ND|NF|NG, ND|NG
  };

  // MS3..MS0 for each multiplexed slot
  localparam logic [3:0] SELECT_TABLE [SELECT_ENTRIES] = '{
    4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5
  };

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

endpackage
`default_nettype wire

>>> rtl/core/msds_font.sv
// Character font lookup for sixteen- and seven-segment digits.
`default_nettype none
module msds_font
  import msds_pkg::*;
(
  input  wire logic [7:0]  character,
  input  wire logic        wide,
  output logic      [15:0] glyph
);

  logic [7:0] up_off;
  logic [7:0] lo_off;
  logic [7:0] dig_off;
  logic       is_up;
  logic       is_lo;
  logic       is_dig;

  assign up_off  = character - CH_UPPER_A;
  assign lo_off  = character - CH_LOWER_A;
  assign dig_off = character - CH_ZERO;
  assign is_up   = (character >= CH_UPPER_A) && (character <= CH_UPPER_Z);
  assign is_lo   = (character >= CH_LOWER_A) && (character <= CH_LOWER_Z);
  assign is_dig  = (character >= CH_ZERO) && (character <= CH_NINE);

  always_comb begin
    glyph = '0;
    if (wide) begin
      if (is_up) begin
        glyph = WIDE_LETTERS[up_off[4:0]];
      end else if (is_lo) begin
        glyph = WIDE_LETTERS[lo_off[4:0]];
      end else if (is_dig) begin
        glyph = WIDE_DIGITS[dig_off[3:0]];
      end else if (character == CH_MINUS) begin
        glyph = WG1 | WG2;
      end else if (character == CH_PLUS) begin
        glyph = WG1 | WG2 | WI | WL;
      end else if (character == CH_LESS) begin
        glyph = WJ | WK;
      end else if (character == CH_GREATER) begin
        glyph = WH | WM;
      end else if (character == CH_SLASH) begin
        glyph = WJ | WM;
      end
    end else begin
      if (is_up) begin
        glyph = {8'h00, NARROW_LETTERS[up_off[4:0]]};
      end else if (is_lo) begin
        glyph = {8'h00, NARROW_LETTERS[lo_off[4:0]]};
      end else if (is_dig) begin
        glyph = {8'h00, NARROW_DIGITS[dig_off[3:0]]};
      end else if (character == CH_MINUS) begin
        glyph = {8'h00, NG};
      end else if (character == CH_UNDER) begin
        glyph = {8'h00, ND};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/msds_frame.sv
// Frame store, command execution and scan pointer.
`default_nettype none
module msds_frame
  import msds_pkg::*;
#(
  parameter int UPPER_DIGITS  = DEF_UPPER_DIGITS,
  parameter int LOWER_DIGITS  = DEF_LOWER_DIGITS,
  parameter int TURRET_DIGITS = DEF_TURRET_DIGITS,
  parameter int LED_COUNT     = DEF_LED_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire cmd_word_t   cmd,
  input  wire logic [15:0] glyph,
  output res_word_t        scan_word
);

`include "multiplexed_segment_display_scanner_unit_macros.svh"

  localparam int LED_SLOT    = UPPER_DIGITS + LOWER_DIGITS;
  localparam int MUX_SLOTS   = LED_SLOT + 1;
  localparam int TURRET_BASE = MUX_SLOTS;
  localparam int ALL_SLOTS   = MUX_SLOTS + TURRET_DIGITS;
  localparam int SCAN_SLOTS  = (ALL_SLOTS > STORE_DEPTH) ? STORE_DEPTH : ALL_SLOTS;
  localparam logic [3:0] LED_IDX = LED_SLOT[3:0];

  logic [15:0] store      [STORE_DEPTH];
  logic [15:0] store_next [STORE_DEPTH];
  logic [3:0]  scan;
  logic [3:0]  scan_next;
  logic [4:0]  scan_inc;
  logic [4:0]  base;
  logic [3:0]  count;
  logic [5:0]  put_idx;
  logic [5:0]  span_end;
  logic        tur;

  // group span: base slot and digit count
  always_comb begin
    base  = '0;
    count = '0;
    case (cmd.group)
      GRP_UPPER: begin
        base  = 5'd0;
        count = 4'(UPPER_DIGITS);
      end
      GRP_LOWER: begin
        base  = 5'(UPPER_DIGITS);
        count = 4'(LOWER_DIGITS);
      end
      GRP_TURRET: begin
        base  = 5'(TURRET_BASE);
        count = 4'(TURRET_DIGITS);
      end
      default: begin
        base  = '0;
        count = '0;
      end
    endcase
  end

  assign put_idx  = {2'b00, cmd.position} + {1'b0, base};
  assign span_end = {1'b0, base} + {2'b00, count};

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_next[i] = store[i];
    end
    unique case (cmd.op)
      OP_PUT: begin
        if ((cmd.position < count) && (put_idx < 6'(STORE_DEPTH))) begin
          store_next[put_idx[3:0]] = glyph;
        end
      end
      OP_RAW: begin
        if (int'(cmd.position) < MUX_SLOTS) begin
          store_next[cmd.position] = cmd.raw_data;
        end
      end
      OP_LED: begin
        if ((int'(cmd.position) < LED_COUNT) && (LED_SLOT < STORE_DEPTH)) begin
          store_next[LED_IDX][cmd.position] = cmd.enable;
        end
      end
      OP_FILL: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          store_next[i] = {16{cmd.enable}};
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if ((6'(i) >= {1'b0, base}) && (6'(i) < span_end)) begin
            store_next[i] = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // scan read and advance
  assign tur      = int'(scan) >= TURRET_BASE;
  assign scan_inc = {1'b0, scan} + 5'd1;
  assign scan_next = (int'(scan_inc) < SCAN_SLOTS) ? scan_inc[3:0] : 4'd0;

  always_comb begin
    scan_word.slot      = scan;
    scan_word.is_turret = tur;
    if (tur) begin
      scan_word.segment_data = {8'h00, store[scan][7:0]};
      scan_word.select_code  = 4'(int'(scan) - TURRET_BASE);
    end else begin
      scan_word.segment_data = store[scan];
      scan_word.select_code  = (int'(scan) < SELECT_ENTRIES) ? SELECT_TABLE[scan] : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= '0;
      end
    end else if (fire) begin
      if (cmd.op == OP_TICK) begin
        scan <= scan_next;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  `MSDS_ASSERT_IMP(a_scan_range, 1'b1, int'(scan) < SCAN_SLOTS, "scan pointer past slot count")
  `MSDS_ASSERT_NXT(a_scan_hold, fire && (cmd.op != OP_TICK), $stable(scan), "scan moved on a write")
  `MSDS_ASSERT_NXT(a_fill_zero, fire && (cmd.op == OP_FILL) && !cmd.enable, store[0] == 16'h0000,
                   "fill with zeros left a word set")

endmodule
`default_nettype wire

>>> rtl/core/multiplexed_segment_display_scanner_unit.sv
// Top level of the multiplexed segment display scanner.
// The block holds a 16-word frame store laid out as the upper sixteen-segment
// digits, the lower seven-segment digits, one LED word and the turret digits.
// Command words render a character, write a raw word, set an LED bit, fill the
// store or clear a group; a tick command returns one result word (slot, turret
// flag, stored segments, select code) and steps the scan, which wraps after the
// last slot. Each command sits in the command register, runs through the font
// lookup and store update, and a tick lands in the result register. A new
// command word is taken every cycle; only a tick waits, and only while the
// result register still holds an untaken word. Reset clears the store at once.
`default_nettype none
module multiplexed_segment_display_scanner_unit
  import msds_pkg::*;
#(
  parameter int UPPER_DIGITS  = DEF_UPPER_DIGITS,
  parameter int LOWER_DIGITS  = DEF_LOWER_DIGITS,
  parameter int TURRET_DIGITS = DEF_TURRET_DIGITS,
  parameter int LED_COUNT     = DEF_LED_COUNT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_word_t cmd_word,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_word_t      res_word
);

`include "multiplexed_segment_display_scanner_unit_macros.svh"

  // command register
  cmd_word_t   held;
  logic        held_valid;
  // execute strobe for the held command
  logic        fire;
  logic        fire_tick;
  logic [15:0] glyph;
  res_word_t   scan_word;

  // a tick needs room in the result register; other commands never stall
  assign fire_tick = held_valid && (held.op == OP_TICK);
  assign fire      = held_valid && ((held.op != OP_TICK) || !res_valid || res_ready);
  assign cmd_ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd_ready) begin
      held_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      held <= cmd_word;
    end
  end

  // upper group uses the sixteen-segment font, the rest seven-segment
  msds_font u_font (
    .character (held.character),
    .wide      (held.group == GRP_UPPER),
    .glyph     (glyph)
  );

  msds_frame #(
    .UPPER_DIGITS  (UPPER_DIGITS),
    .LOWER_DIGITS  (LOWER_DIGITS),
    .TURRET_DIGITS (TURRET_DIGITS),
    .LED_COUNT     (LED_COUNT)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .cmd       (held),
    .glyph     (glyph),
    .scan_word (scan_word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && fire_tick) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && fire_tick) begin
      res_word <= scan_word;
    end
  end

  `MSDS_ASSERT_IMP(a_tick_room, fire && fire_tick, !res_valid || res_ready,
                   "tick executed over an untaken result")

endmodule
`default_nettype wire
